### design/stq_pkg.sv
// package for the sorted timer queue: beat types, modes, slot states, fsm states
// no dependencies
`default_nettype none
package stq_pkg;
	localparam int MaxOut = 16;

	typedef enum logic [2:0] {
		MODE_SETUP   = 3'd0,
		MODE_START   = 3'd1,
		MODE_RESTART = 3'd2,
		MODE_STOP    = 3'd3,
		MODE_TICK    = 3'd4,
		MODE_QUERY   = 3'd5,
		MODE_RSVD6   = 3'd6,
		MODE_RSVD7   = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_SLEEP = 2'd0,
		ST_RUN   = 2'd1,
		ST_DONE  = 2'd2,
		ST_RSVD  = 2'd3
	} slot_st_t;

	typedef enum logic {
		KIND_EXPIRY = 1'b0,
		KIND_QUERY  = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_OP,
		FSM_SCAN,
		FSM_FIND,
		FSM_EMIT
	} fsm_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [3:0]  timer_index;
		logic [31:0] timeout_ticks;
		logic        periodic;
	} in_beat_t;

	typedef struct packed {
		logic       report_kind;
		logic [3:0] slot_index;
		logic [1:0] slot_state;
		logic       last;
	} out_beat_t;
endpackage
`default_nettype wire

### design/sorted_timer_queue_unit.sv
// top level of the sorted timer queue: slot registers, sequencer, output register
// depends on stq_pkg
//
// usage: one input channel (in_valid/in_ready/in_beat) carries commands, one
// output channel (out_valid/out_ready/out_beat) carries expiry reports and
// query replies. in_ready is high only while the sequencer is idle.
// a slot command is applied in the op step. a query reply is loaded into the
// output register from the op step once that register is free. a tick scans
// every slot for due ones, then for each due slot runs an ordering search over
// all slots through the shared lag and age compare unit and an emit step, with
// last set on the final report beat.
// results wait in a single output register; a stalled receiver holds the
// sequencer in its op or emit step and nothing is lost.
// reset clears the tick counter, start sequence and all slot state at once.
`default_nettype none
module sorted_timer_queue_unit import stq_pkg::*; #(
	parameter int TIMER_SLOTS = 16,
	parameter int TICK_BITS   = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_beat_t  in_beat,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_beat_t      out_beat
);
	localparam int PW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CW = $clog2(MaxOut + 1);
	localparam logic [PW-1:0] PtrEnd = PW'(TIMER_SLOTS - 1);

	fsm_t state_q, state_d;
	logic [TICK_BITS-1:0] now_q;
	logic [31:0] seq_q, seq_snap_q;
	logic [TICK_BITS-1:0] deadline_q [TIMER_SLOTS];
	logic [TICK_BITS-1:0] tmo_q      [TIMER_SLOTS];
	logic                 rep_q      [TIMER_SLOTS];
	slot_st_t             st_q       [TIMER_SLOTS];
	logic [31:0]          stamp_q    [TIMER_SLOTS];
	logic [TIMER_SLOTS-1:0] cand_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] ptr_q;
	in_beat_t cmd_q;
	logic have_q;
	logic [PW-1:0] best_q;
	logic [TICK_BITS-1:0] best_lag_q;
	logic [31:0] best_age_q;
	out_beat_t out_q;
	logic out_valid_q;

	logic out_free, ok, accept, at_end, out_load;
	logic [TICK_BITS-1:0] lag, tmo_in, span;
	logic [31:0] age;
	logic wins;

	assign out_free = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign ok       = {28'd0, cmd_q.timer_index} < TIMER_SLOTS;
	assign at_end   = ptr_q == PtrEnd;
	assign lag      = now_q - deadline_q[ptr_q];
	assign age      = seq_snap_q - stamp_q[ptr_q];
	assign tmo_in   = TICK_BITS'(cmd_q.timeout_ticks);
	assign span     = (tmo_q[ptr_q] == '0) ? TICK_BITS'(1) : tmo_q[ptr_q];
	assign wins     = !have_q || (lag > best_lag_q) ||
		(lag == best_lag_q && age < best_age_q);
	assign out_load = out_free && ((state_q == FSM_OP && mode_t'(cmd_q.mode) == MODE_QUERY) ||
		state_q == FSM_EMIT);
	assign in_ready  = state_q == FSM_IDLE;
	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FSM_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (accept) state_d = (mode_t'(in_beat.mode) == MODE_TICK) ? FSM_SCAN : FSM_OP;
			end
			FSM_OP: begin
				if (mode_t'(cmd_q.mode) != MODE_QUERY || out_free) state_d = FSM_IDLE;
			end
			FSM_SCAN: begin
				if (at_end) state_d = (cnt_q == '0 && !(st_q[ptr_q] == ST_RUN &&
					!lag[TICK_BITS-1])) ? FSM_IDLE : FSM_FIND;
			end
			FSM_FIND: begin
				if (at_end) state_d = FSM_EMIT;
			end
			FSM_EMIT: begin
				if (out_free) state_d = (cnt_q == CW'(1)) ? FSM_IDLE : FSM_FIND;
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			seq_q <= '0;
			seq_snap_q <= '0;
			cand_q <= '0;
			cnt_q <= '0;
			ptr_q <= '0;
			cmd_q <= '0;
			have_q <= 1'b0;
			best_q <= '0;
			best_lag_q <= '0;
			best_age_q <= '0;
			out_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < TIMER_SLOTS; i++) begin
				deadline_q[i] <= '0;
				tmo_q[i] <= '0;
				rep_q[i] <= 1'b0;
				st_q[i] <= ST_SLEEP;
				stamp_q[i] <= '0;
			end
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				FSM_IDLE: begin
					if (accept) begin
						cmd_q <= in_beat;
						ptr_q <= (mode_t'(in_beat.mode) == MODE_TICK) ? '0 :
							PW'(in_beat.timer_index);
						cand_q <= '0;
						cnt_q <= '0;
						seq_snap_q <= seq_q;
						if (mode_t'(in_beat.mode) == MODE_TICK) now_q <= now_q + 1'b1;
					end
				end
				FSM_OP: begin
					case (mode_t'(cmd_q.mode))
						MODE_QUERY: begin
							if (out_free) begin
								out_q.report_kind <= KIND_QUERY;
								out_q.slot_index <= cmd_q.timer_index;
								out_q.slot_state <= ok ? st_q[ptr_q] : ST_SLEEP;
								out_q.last <= 1'b1;
								if (ok && st_q[ptr_q] == ST_DONE) st_q[ptr_q] <= ST_SLEEP;
							end
						end
						MODE_SETUP: if (ok) begin
							tmo_q[ptr_q] <= tmo_in;
							rep_q[ptr_q] <= cmd_q.periodic;
							st_q[ptr_q] <= ST_SLEEP;
						end
						MODE_START: if (ok) begin
							deadline_q[ptr_q] <= now_q + tmo_q[ptr_q];
							st_q[ptr_q] <= ST_RUN;
							stamp_q[ptr_q] <= seq_q;
							seq_q <= seq_q + 1'b1;
						end
						MODE_RESTART: if (ok) begin
							tmo_q[ptr_q] <= tmo_in;
							rep_q[ptr_q] <= cmd_q.periodic;
							deadline_q[ptr_q] <= now_q + tmo_in;
							st_q[ptr_q] <= ST_RUN;
							stamp_q[ptr_q] <= seq_q;
							seq_q <= seq_q + 1'b1;
						end
						MODE_STOP: if (ok) begin
							deadline_q[ptr_q] <= '0;
							tmo_q[ptr_q] <= '0;
							st_q[ptr_q] <= ST_SLEEP;
						end
						default: ;
					endcase
				end
				FSM_SCAN: begin
					if (st_q[ptr_q] == ST_RUN && !lag[TICK_BITS-1] && cnt_q != CW'(MaxOut)) begin
						cand_q[ptr_q] <= 1'b1;
						cnt_q <= cnt_q + 1'b1;
					end
					ptr_q <= at_end ? '0 : ptr_q + 1'b1;
					have_q <= 1'b0;
				end
				FSM_FIND: begin
					if (cand_q[ptr_q] && wins) begin
						have_q <= 1'b1;
						best_q <= ptr_q;
						best_lag_q <= lag;
						best_age_q <= age;
					end
					ptr_q <= at_end ? ((cand_q[ptr_q] && wins) ? ptr_q : best_q) :
						ptr_q + 1'b1;
				end
				FSM_EMIT: begin
					if (out_free) begin
						out_q.report_kind <= KIND_EXPIRY;
						out_q.slot_index <= 4'(ptr_q);
						out_q.slot_state <= ST_RUN;
						out_q.last <= cnt_q == CW'(1);
						cand_q[ptr_q] <= 1'b0;
						cnt_q <= cnt_q - 1'b1;
						have_q <= 1'b0;
						if (rep_q[ptr_q]) begin
							deadline_q[ptr_q] <= now_q + span;
							stamp_q[ptr_q] <= seq_q;
							seq_q <= seq_q + 1'b1;
						end else begin
							st_q[ptr_q] <= ST_DONE;
						end
						ptr_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

### design/stq_checker.sv
// port-level checks for the sorted timer queue, bound to the top level
// depends on stq_pkg and sorted_timer_queue_unit
`default_nettype none
module stq_checker import stq_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_beat_t out_beat
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_beat))
		else $error("output beat changed while stalled");
	a_query_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_beat.report_kind == KIND_QUERY |-> out_beat.last)
		else $error("query reply not last");
	a_expiry_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_beat.report_kind == KIND_EXPIRY |-> out_beat.slot_state == ST_RUN)
		else $error("expiry with wrong state");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accept");
endmodule

bind sorted_timer_queue_unit stq_checker u_stq_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_beat(out_beat)
);
`default_nettype wire

### tb/sv/sorted_timer_queue_unit_tb.sv
// testbench for the sorted timer queue: directed and random command beats with a
// transaction-level predictor of slot state and expiry order; depends on stq_pkg and the top level
`timescale 1ns / 1ps
`default_nettype none
module sorted_timer_queue_unit_tb;
	import stq_pkg::*;

	class timer_board;
		logic [31:0] now_tick;
		logic [31:0] start_seq;
		logic [31:0] due_at [16];
		logic [31:0] span [16];
		logic        rearm [16];
		slot_st_t    status [16];
		logic [31:0] stamp [16];
		out_beat_t   pending [$];
		int          errors;
		int          expiries;
		int          replies;

		function new();
			now_tick = '0;
			start_seq = '0;
			errors = 0;
			expiries = 0;
			replies = 0;
			for (int i = 0; i < 16; i++) begin
				due_at[i] = '0;
				span[i] = '0;
				rearm[i] = 1'b0;
				status[i] = ST_SLEEP;
				stamp[i] = '0;
			end
		endfunction

		function void arm(int s, logic [31:0] d);
			due_at[s] = now_tick + d;
			status[s] = ST_RUN;
			stamp[s] = start_seq;
			start_seq = start_seq + 1;
		endfunction

		function bit ahead(int a, int b);
			logic [31:0] la;
			logic [31:0] lb;
			la = now_tick - due_at[a];
			lb = now_tick - due_at[b];
			if (la != lb)
				return la > lb;
			return (start_seq - stamp[a]) < (start_seq - stamp[b]);
		endfunction

		function void note_command(in_beat_t b);
			int due [$];
			int idx;
			int best;
			int t;
			out_beat_t r;
			idx = b.timer_index;
			case (mode_t'(b.mode))
				MODE_TICK: begin
					now_tick = now_tick + 1;
					for (int s = 0; s < 16; s++)
						if (status[s] == ST_RUN && !((now_tick - due_at[s]) >> 31))
							due.push_back(s);
					for (int i = 0; i < due.size(); i++) begin
						best = i;
						for (int j = i + 1; j < due.size(); j++)
							if (ahead(due[j], due[best]))
								best = j;
						t = due[best];
						due[best] = due[i];
						due[i] = t;
					end
					for (int i = 0; i < due.size(); i++) begin
						r.report_kind = KIND_EXPIRY;
						r.slot_index = 4'(due[i]);
						r.slot_state = ST_RUN;
						r.last = (i == due.size() - 1);
						pending.push_back(r);
						if (rearm[due[i]])
							arm(due[i], span[due[i]] == 0 ? 32'd1 : span[due[i]]);
						else
							status[due[i]] = ST_DONE;
					end
				end
				MODE_QUERY: begin
					r.report_kind = KIND_QUERY;
					r.slot_index = b.timer_index;
					r.slot_state = status[idx];
					r.last = 1'b1;
					pending.push_back(r);
					if (status[idx] == ST_DONE)
						status[idx] = ST_SLEEP;
				end
				MODE_SETUP: begin
					span[idx] = b.timeout_ticks;
					rearm[idx] = b.periodic;
					status[idx] = ST_SLEEP;
				end
				MODE_START: arm(idx, span[idx]);
				MODE_RESTART: begin
					span[idx] = b.timeout_ticks;
					rearm[idx] = b.periodic;
					arm(idx, b.timeout_ticks);
				end
				MODE_STOP: begin
					due_at[idx] = '0;
					span[idx] = '0;
					status[idx] = ST_SLEEP;
				end
				default: ;
			endcase
		endfunction

		function void check_report(out_beat_t a);
			out_beat_t e;
			if (pending.size() == 0) begin
				$error("unexpected report beat %h", a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.report_kind == KIND_EXPIRY)
				expiries++;
			else
				replies++;
			if (a.report_kind !== e.report_kind) begin
				$error("report_kind expected %0d actual %0d", e.report_kind, a.report_kind);
				errors++;
			end
			if (a.slot_index !== e.slot_index) begin
				$error("slot_index expected %0d actual %0d", e.slot_index, a.slot_index);
				errors++;
			end
			if (a.slot_state !== e.slot_state) begin
				$error("slot_state expected %0d actual %0d", e.slot_state, a.slot_state);
				errors++;
			end
			if (a.last !== e.last) begin
				$error("last expected %0d actual %0d", e.last, a.last);
				errors++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_beat_t  in_beat;
	logic      out_valid;
	logic      out_ready;
	out_beat_t out_beat;

	timer_board board;
	int        quiet_cycles;
	bit        stimulus_done;

	sorted_timer_queue_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_beat(in_beat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_beat(out_beat)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send(mode_t m, int idx, logic [31:0] tmo, logic per);
		in_beat_t b;
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		b.mode = m;
		b.timer_index = 4'(idx);
		b.timeout_ticks = tmo;
		b.periodic = per;
		in_valid <= 1'b1;
		in_beat <= b;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_command(b);
	endtask

	task automatic send_random();
		int p;
		int idx;
		logic [31:0] tmo;
		p = $urandom_range(0, 99);
		idx = $urandom_range(0, 15);
		tmo = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 6);
		if (p < 40)
			send(MODE_TICK, $urandom_range(0, 15), $urandom(), 1'($urandom_range(0, 1)));
		else if (p < 55)
			send(MODE_RESTART, idx, tmo, 1'($urandom_range(0, 1)));
		else if (p < 63)
			send(MODE_SETUP, idx, tmo, 1'($urandom_range(0, 1)));
		else if (p < 73)
			send(MODE_START, idx, tmo, 1'($urandom_range(0, 1)));
		else if (p < 78)
			send(MODE_STOP, idx, tmo, 1'($urandom_range(0, 1)));
		else if (p < 96)
			send(MODE_QUERY, idx, tmo, 1'($urandom_range(0, 1)));
		else
			send($urandom_range(0, 1) ? MODE_RSVD6 : MODE_RSVD7, idx, $urandom(), 1'b1);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.check_report(out_beat);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > 20000) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int g;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stimulus_done || $urandom_range(0, 3) != 0) begin
				out_ready <= 1'b1;
			end else begin
				g = 1 + gap_len();
				out_ready <= 1'b0;
				repeat (g) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int waited;
		board = new();
		quiet_cycles = 0;
		stimulus_done = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_beat = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// equal deadlines: later start first; zero periodic timeout; wrap of timeout
		send(MODE_SETUP, 0, 32'd2, 1'b0);
		send(MODE_SETUP, 15, 32'hFFFF_FFFF, 1'b1);
		send(MODE_START, 0, 32'd0, 1'b0);
		send(MODE_RESTART, 1, 32'd2, 1'b1);
		send(MODE_RESTART, 2, 32'd0, 1'b1);
		send(MODE_RESTART, 3, 32'h8000_0000, 1'b0);
		send(MODE_RESTART, 4, 32'h7FFF_FFFF, 1'b0);
		send(MODE_START, 15, 32'd0, 1'b0);
		send(MODE_TICK, 0, 32'd0, 1'b0);
		send(MODE_TICK, 15, 32'hFFFF_FFFF, 1'b1);
		send(MODE_QUERY, 0, 32'd0, 1'b0);
		send(MODE_QUERY, 0, 32'd0, 1'b0);
		send(MODE_QUERY, 1, 32'd0, 1'b0);
		send(MODE_STOP, 1, 32'hFFFF_FFFF, 1'b1);
		send(MODE_QUERY, 1, 32'd0, 1'b0);
		send(MODE_RSVD6, 5, 32'd1, 1'b1);
		send(MODE_RSVD7, 5, 32'd1, 1'b1);
		for (int i = 0; i < 16; i++)
			send(MODE_RESTART, i, 32'd1, i[0]);
		send(MODE_TICK, 0, 32'd0, 1'b0);
		send(MODE_QUERY, 15, 32'd0, 1'b0);

		for (int n = 0; n < 65; n++)
			send_random();
		in_valid <= 1'b0;
		stimulus_done = 1'b1;

		waited = 0;
		while (board.pending.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (300) @(posedge clk);
		$display("covered %0d expiry reports and %0d query replies, final tick %0d",
			board.expiries, board.replies, board.now_tick);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire

### sim.f
design/stq_pkg.sv
design/sorted_timer_queue_unit.sv
design/stq_checker.sv
tb/sv/sorted_timer_queue_unit_tb.sv
